>>> rtl/core/hsfc_pkg.sv
// Shared constants for the half/single float converter.
package hsfc_pkg;

    localparam int unsigned SGL_W     = 32;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned SGL_EXP_W = 8;
    localparam int unsigned SGL_MAN_W = 23;
    localparam int unsigned HALF_EXP_W = 5;
    localparam int unsigned HALF_MAN_W = 10;

    localparam logic [SGL_EXP_W-1:0]  SGL_EXP_MAX  = 8'hFF;
    localparam logic [HALF_EXP_W-1:0] HALF_EXP_MAX = 5'h1F;

    // Bias difference 127 - 15.
    localparam logic [SGL_EXP_W-1:0] BIAS_DIFF   = 8'd112;
    // Single exponent at or above this overflows half.
    localparam logic [SGL_EXP_W-1:0] OVF_EXP     = 8'd143;
    // Single exponent at or below this lands in half subnormal range.
    localparam logic [SGL_EXP_W-1:0] SUB_EXP     = 8'd112;
    // Below this, the round bit is shifted out too (shift above 24).
    localparam logic [SGL_EXP_W-1:0] SUB_MIN_EXP = 8'd102;
    // Subnormal shift is SUB_SH_BASE - exponent.
    localparam logic [SGL_EXP_W-1:0] SUB_SH_BASE = 8'd126;
    // Single exponent of a renormalized half subnormal is this minus the shift.
    localparam logic [SGL_EXP_W-1:0] SUBN_EXP_BASE = 8'd113;

    localparam logic [HALF_W-1:0] HALF_INF = 16'h7C00;
    localparam logic [HALF_W-1:0] HALF_NAN = 16'hFE00;
    localparam logic [SGL_W-1:0]  SGL_NAN  = 32'hFFC00000;

    typedef enum logic {
        OP_TO_HALF   = 1'b0,
        OP_TO_SINGLE = 1'b1
    } op_t;

endpackage

>>> rtl/core/hsfc_to_half.sv
// Binary32 to binary16 conversion logic, round half up.
module hsfc_to_half
    import hsfc_pkg::*;
(
    input  logic [SGL_W-1:0]  f,
    output logic [HALF_W-1:0] h
);

    logic                     sign;
    logic [SGL_EXP_W-1:0]     ef;
    logic [SGL_MAN_W-1:0]     man;
    logic [SGL_MAN_W:0]       man_h;
    logic [SGL_EXP_W-1:0]     sh_full;
    logic [4:0]               sh;
    logic [SGL_MAN_W:0]       shifted;
    logic [HALF_MAN_W:0]      hm;
    logic [SGL_EXP_W-1:0]     hexp;
    logic [HALF_W-1:0]        norm;

    assign sign    = f[SGL_W-1];
    assign ef      = f[SGL_W-2 -: SGL_EXP_W];
    assign man     = f[SGL_MAN_W-1:0];
    assign man_h   = {1'b1, man};
    assign sh_full = SUB_SH_BASE - ef;
    assign sh      = sh_full[4:0];
    assign shifted = man_h >> sh;
    assign hm      = shifted[HALF_MAN_W:0] + {{HALF_MAN_W{1'b0}}, man_h[sh - 5'd1]};
    assign hexp    = ef - BIAS_DIFF;
    assign norm    = {sign, hexp[HALF_EXP_W-1:0], man[SGL_MAN_W-1 -: HALF_MAN_W]}
                     + {{(HALF_W-1){1'b0}}, man[SGL_MAN_W-HALF_MAN_W-1]};

    always_comb
    begin
        if (ef == '0)
        begin
            h = {sign, {(HALF_W-1){1'b0}}};
        end
        else if (ef == SGL_EXP_MAX)
        begin
            h = (man == '0) ? (HALF_INF | {sign, {(HALF_W-1){1'b0}}}) : HALF_NAN;
        end
        else if (ef >= OVF_EXP)
        begin
            h = HALF_INF | {sign, {(HALF_W-1){1'b0}}};
        end
        else if (ef <= SUB_EXP)
        begin
            if (ef >= SUB_MIN_EXP)
            begin
                h = {sign, {(HALF_W-HALF_MAN_W-2){1'b0}}, hm};
            end
            else
            begin
                h = {sign, {(HALF_W-1){1'b0}}};
            end
        end
        else
        begin
            h = norm;
        end
    end

endmodule

>>> rtl/core/hsfc_to_single.sv
// Binary16 to binary32 conversion logic with subnormal renormalization.
module hsfc_to_single
    import hsfc_pkg::*;
(
    input  logic [HALF_W-1:0] h,
    output logic [SGL_W-1:0]  f
);

    logic                    sign;
    logic [HALF_EXP_W-1:0]   ef;
    logic [HALF_MAN_W-1:0]   man;
    logic [3:0]              lead;
    logic [3:0]              shifts;
    logic [HALF_MAN_W-1:0]   man_n;
    logic [SGL_EXP_W-1:0]    sexp;
    logic [HALF_MAN_W-1:0]   man_o;

    assign sign = h[HALF_W-1];
    assign ef   = h[HALF_W-2 -: HALF_EXP_W];
    assign man  = h[HALF_MAN_W-1:0];

    // Position of the leading one.
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < HALF_MAN_W; i++)
        begin
            if (man[i])
            begin
                lead = 4'(i);
            end
        end
    end

    assign shifts = 4'(HALF_MAN_W) - lead;
    assign man_n  = man << shifts;

    always_comb
    begin
        man_o = man;
        sexp  = {3'b000, ef} + BIAS_DIFF;
        f     = '0;
        if (ef == '0)
        begin
            man_o = man_n;
            sexp  = SUBN_EXP_BASE - {4'b0000, shifts};
        end
        else if (ef == HALF_EXP_MAX)
        begin
            sexp = SGL_EXP_MAX;
        end
        if (h[HALF_W-2:0] == '0)
        begin
            f = {sign, {(SGL_W-1){1'b0}}};
        end
        else if (ef == HALF_EXP_MAX && man != '0)
        begin
            f = SGL_NAN;
        end
        else
        begin
            f = {sign, sexp, man_o, {(SGL_MAN_W-HALF_MAN_W){1'b0}}};
        end
    end

endmodule

>>> rtl/core/half_single_float_converter.sv
// Top level of the half/single float converter: input register, conversion, result register.
// Each transaction (start high while busy is low) converts operand in the direction set by op:
// 0 turns a binary32 pattern into a binary16 pattern zero-extended to 32 bits, 1 turns the
// binary16 pattern in operand[15:0] into a binary32 pattern. busy is always low, so a
// transaction can be issued every cycle. The result appears on converted with done high for
// exactly one cycle, once the transaction has passed the input register and then the
// conversion logic into the result register. Results cannot be stalled; the
// receiver must take each one in the cycle done is high.
module half_single_float_converter
    import hsfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              op,
    input  logic [SGL_W-1:0]  operand,
    output logic              done,
    output logic [SGL_W-1:0]  converted
);

    logic              in_vld_reg;
    logic              op_reg;
    logic [SGL_W-1:0]  operand_reg;
    logic              done_reg;
    logic [SGL_W-1:0]  converted_reg;
    logic [SGL_W-1:0]  converted_next;
    logic [HALF_W-1:0] half_res;
    logic [SGL_W-1:0]  sgl_res;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            done_reg   <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg      <= op;
            operand_reg <= operand;
        end
        if (in_vld_reg)
        begin
            converted_reg <= converted_next;
        end
    end

    hsfc_to_half u_to_half
    (
        .f (operand_reg),
        .h (half_res)
    );

    hsfc_to_single u_to_single
    (
        .h (operand_reg[HALF_W-1:0]),
        .f (sgl_res)
    );

    always_comb
    begin
        case (op_t'(op_reg))
            OP_TO_HALF:   converted_next = {{(SGL_W-HALF_W){1'b0}}, half_res};
            OP_TO_SINGLE: converted_next = sgl_res;
            default:      converted_next = sgl_res;
        endcase
    end

    assign done      = done_reg;
    assign converted = converted_reg;

endmodule

>>> dv/half_single_float_converter_test.sv
// Self-checking testbench for the half/single float converter, with a scoreboard class.
module half_single_float_converter_test
    import hsfc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 400;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        op_t              dir;
        logic [SGL_W-1:0] source;
        logic [SGL_W-1:0] value;
    } conversion_t;

    class conversion_scoreboard;
        conversion_t expected_q[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function logic [HALF_W-1:0] half_of_single(logic [SGL_W-1:0] f);
            logic [HALF_W-1:0] sgn;
            logic [SGL_EXP_W-1:0] ef;
            logic [SGL_MAN_W-1:0] man;
            logic [SGL_MAN_W:0] full;
            logic [HALF_W-1:0] r;
            int hexp;
            int sh;
            sgn = {f[SGL_W-1], 15'd0};
            ef = f[30:23];
            man = f[SGL_MAN_W-1:0];
            if (ef == '0)
                return sgn;
            if (ef == SGL_EXP_MAX)
                return (man == '0) ? (sgn | HALF_INF) : HALF_NAN;
            hexp = int'(ef) - int'(BIAS_DIFF);
            if (hexp >= int'(HALF_EXP_MAX))
                return sgn | HALF_INF;
            if (hexp <= 0)
            begin
                // half subnormal: hidden bit shifted in, round on the next lower bit
                sh = 14 - hexp;
                if (sh > 24)
                    return sgn;
                full = {1'b1, man};
                r = 16'(full >> sh);
                if (full[sh-1])
                    r = r + 16'd1;
                return sgn | r;
            end
            r = sgn | 16'(hexp << HALF_MAN_W) | 16'(man >> 13);
            if (man[12])
                r = r + 16'd1;
            return r;
        endfunction

        function logic [SGL_W-1:0] single_of_half(logic [HALF_W-1:0] h);
            logic [HALF_MAN_W-1:0] man;
            logic [HALF_MAN_W:0] norm;
            logic [SGL_EXP_W-1:0] sexp;
            int shifts;
            if (h[14:0] == '0)
                return {h[15], 31'd0};
            man = h[HALF_MAN_W-1:0];
            if (h[14:10] == '0)
            begin
                norm = {1'b0, man};
                shifts = 0;
                while (!norm[HALF_MAN_W] && shifts < 11)
                begin
                    norm = norm << 1;
                    shifts++;
                end
                man = norm[HALF_MAN_W-1:0];
                sexp = SUBN_EXP_BASE - 8'(shifts);
            end
            else if (h[14:10] == HALF_EXP_MAX)
            begin
                if (man != '0)
                    return SGL_NAN;
                sexp = SGL_EXP_MAX;
            end
            else
                sexp = 8'(h[14:10]) + BIAS_DIFF;
            return {h[15], sexp, man, 13'd0};
        endfunction

        function void note(op_t dir, logic [SGL_W-1:0] source);
            conversion_t c;
            c.dir = dir;
            c.source = source;
            if (dir == OP_TO_HALF)
                c.value = {16'd0, half_of_single(source)};
            else
                c.value = single_of_half(source[HALF_W-1:0]);
            expected_q.push_back(c);
        endfunction

        function void check(logic [SGL_W-1:0] got);
            conversion_t c;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: result %h with no transaction pending", $time, got);
                return;
            end
            c = expected_q.pop_front();
            if (got !== c.value)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: mismatch %s operand %h: expected %h, got %h",
                             $time, c.dir.name(), c.source, c.value, got);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             op = 1'b0;
    logic [SGL_W-1:0] operand = '0;
    logic             done;
    logic [SGL_W-1:0] converted;

    conversion_scoreboard sb = new();
    int cycles = 0;
    int burst = 0;

    logic [SGL_W-1:0] to_half_cases [14] = '{
        32'h00000000, 32'h80000000, 32'h807FFFFF, 32'h7F800000, 32'hFF800000,
        32'h7FC00000, 32'hFF800001, 32'h47800000, 32'h477FE000, 32'hC77FF000,
        32'h3F800000, 32'h33000000, 32'h32800000, 32'hB87FFFFF
    };
    logic [SGL_W-1:0] to_single_cases [11] = '{
        32'h00000000, 32'h00008000, 32'h00000001, 32'h000083FF, 32'h00007C00,
        32'h0000FC00, 32'h00007E00, 32'h0000FC01, 32'h00007BFF, 32'hFFFF3C00,
        32'hA5A50001
    };

    half_single_float_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .operand   (operand),
        .done      (done),
        .converted (converted)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note(op_t'(op), operand);
        if (rst_n && done)
            sb.check(converted);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic issue(input op_t dir, input logic [SGL_W-1:0] v);
        int gap;
        if (burst > 0)
        begin
            burst--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 19) == 0)
                burst = $urandom_range(10, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            op <= 1'($urandom());
            operand <= $urandom();
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        op <= dir;
        operand <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        op_t dir;
        logic [SGL_W-1:0] v;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (to_half_cases[i])
            issue(OP_TO_HALF, to_half_cases[i]);
        foreach (to_single_cases[i])
            issue(OP_TO_SINGLE, to_single_cases[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            dir = op_t'($urandom_range(0, 1));
            v = $urandom();
            if (dir == OP_TO_HALF)
            begin
                case ($urandom_range(0, 3))
                    1, 2: v = {1'($urandom()), 8'($urandom_range(100, 145)), 23'($urandom())};
                    3:    v = {1'($urandom()),
                               ($urandom_range(0, 1) ? SGL_EXP_MAX : 8'h00),
                               ($urandom_range(0, 3) == 0 ? 23'd0 : 23'($urandom()))};
                    default: ;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: v[14:10] = 5'h00;
                    1: v[14:10] = HALF_EXP_MAX;
                    default: ;
                endcase
            end
            issue(dir, v);
        end
        start <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/core/hsfc_pkg.sv
rtl/core/hsfc_to_half.sv
rtl/core/hsfc_to_single.sv
rtl/core/half_single_float_converter.sv
dv/half_single_float_converter_test.sv
